/* rtl/pctd_pkg.sv */
// package for the prefix code tree decoder
// node record, op and status codes, table sizing and handshake structs
// no dependencies
package pctd_pkg;

  localparam int NODE_COUNT      = 512;
  localparam int BIT_COUNT_WIDTH = 48;

  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int CNT_IN_W   = 48;
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  localparam int BIT_IDX_W  = $clog2(BYTE_W + 1);
  localparam int BIT_SEL_W  = $clog2(BYTE_W);

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd2;

  localparam logic STAT_OK        = 1'b0;
  localparam logic STAT_NO_STREAM = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef struct packed {
    logic               valid;
    logic [NODE_AW-1:0] addr;
    node_t              node;
  } mem_wr_t;

  typedef struct packed {
    logic               en;
    logic [NODE_AW-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             status;
  } push_t;

  function automatic logic in_table(input logic [IDX_W-1:0] idx);
    return 32'(idx) < NODE_COUNT;
  endfunction

  function automatic logic [NODE_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    return NODE_AW'(idx);
  endfunction

endpackage

/* rtl/pctd_node_mem.sv */
// code tree node table: one write port, one registered read port
// depends on pctd_pkg
module pctd_node_mem
  import pctd_pkg::*;
(
  input  logic    clk,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output node_t   rdata
);

  node_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr.addr] <= wr.node;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

/* rtl/pctd_result_reg.sv */
// output register for decoded results
// depends on pctd_pkg
module pctd_result_reg
  import pctd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] symbol,
  output logic             last,
  output logic             status
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      symbol <= push.symbol;
      last   <= push.last;
      status <= push.status;
    end
  end

endmodule

/* rtl/pctd_walk_ctrl.sv */
// sequencer: takes ops, walks the code tree one bit per cycle through the node table
// when not stalled; keeps stream state and one pending result so last can be set
// depends on pctd_pkg
module pctd_walk_ctrl
  import pctd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [IDX_W-1:0]    node_index,
  input  logic                node_is_leaf,
  input  logic [IDX_W-1:0]    node_left,
  input  logic [IDX_W-1:0]    node_right,
  input  logic [SYM_W-1:0]    node_symbol,
  input  logic [CNT_IN_W-1:0] bit_count,
  input  logic [BYTE_W-1:0]   data_byte,
  output mem_wr_t             mem_wr,
  output mem_rd_t             mem_rd,
  input  node_t               mem_rdata,
  output push_t               push,
  input  logic                out_free
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_END  = 3'b100
  } state_t;

  state_t                     state, state_next;
  logic [BIT_COUNT_WIDTH-1:0] rem, rem_next;
  logic [IDX_W-1:0]           cur_idx, cur_idx_next;
  logic                       active, active_next;
  logic [IDX_W-1:0]           fetch_idx, fetch_idx_next;
  logic                       fetch_ok, fetch_ok_next;
  logic                       check_leaf, check_leaf_next;
  logic [BIT_IDX_W-1:0]       bit_idx, bit_idx_next;
  logic [BYTE_W-1:0]          data_reg, data_reg_next;
  node_t                      root, root_next;
  logic                       pend_valid, pend_valid_next;
  logic [SYM_W-1:0]           pend_sym, pend_sym_next;
  logic                       pend_status, pend_status_next;

  node_t            fetched;
  node_t            base;
  logic             emit;
  logic             blocked;
  logic             more;
  logic [IDX_W-1:0] child;
  logic             accept;
  node_t            new_node;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign new_node = '{leaf: node_is_leaf, left: node_left, right: node_right, sym: node_symbol};

  assign fetched = fetch_ok ? mem_rdata : '0;
  assign emit    = check_leaf && fetched.leaf;
  assign base    = emit ? root : fetched;
  assign blocked = emit && pend_valid && !out_free;
  assign more    = (bit_idx != BIT_IDX_W'(BYTE_W)) && (rem != '0);
  assign child   = data_reg[bit_idx[BIT_SEL_W-1:0]] ? base.right : base.left;

  always_comb begin
    state_next       = state;
    rem_next         = rem;
    cur_idx_next     = cur_idx;
    active_next      = active;
    fetch_idx_next   = fetch_idx;
    fetch_ok_next    = fetch_ok;
    check_leaf_next  = check_leaf;
    bit_idx_next     = bit_idx;
    data_reg_next    = data_reg;
    root_next        = root;
    pend_valid_next  = pend_valid;
    pend_sym_next    = pend_sym;
    pend_status_next = pend_status;
    mem_wr           = '0;
    mem_rd           = '0;
    push             = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              if (in_table(node_index)) begin
                mem_wr.valid = 1'b1;
                mem_wr.addr  = to_addr(node_index);
                mem_wr.node  = new_node;
                if (node_index == '0) begin
                  root_next = new_node;
                end
              end
            end
            OP_START: begin
              rem_next     = BIT_COUNT_WIDTH'(bit_count);
              cur_idx_next = '0;
              active_next  = 1'b1;
            end
            OP_DATA: begin
              if (!active) begin
                pend_valid_next  = 1'b1;
                pend_sym_next    = '0;
                pend_status_next = STAT_NO_STREAM;
                state_next       = ST_END;
              end else if (rem != '0) begin
                mem_rd.en       = 1'b1;
                mem_rd.addr     = to_addr(cur_idx);
                fetch_idx_next  = cur_idx;
                fetch_ok_next   = in_table(cur_idx);
                check_leaf_next = 1'b0;
                bit_idx_next    = '0;
                data_reg_next   = data_byte;
                state_next      = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (!blocked) begin
          if (emit) begin
            if (pend_valid) begin
              push.valid  = 1'b1;
              push.symbol = pend_sym;
              push.last   = 1'b0;
              push.status = pend_status;
            end
            pend_valid_next  = 1'b1;
            pend_sym_next    = fetched.sym;
            pend_status_next = STAT_OK;
          end
          if (more) begin
            mem_rd.en       = 1'b1;
            mem_rd.addr     = to_addr(child);
            fetch_idx_next  = child;
            fetch_ok_next   = in_table(child);
            check_leaf_next = 1'b1;
            rem_next        = rem - BIT_COUNT_WIDTH'(1);
            bit_idx_next    = bit_idx + BIT_IDX_W'(1);
          end else begin
            cur_idx_next = emit ? '0 : fetch_idx;
            state_next   = ST_END;
          end
        end
      end
      ST_END: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          push.valid      = 1'b1;
          push.symbol     = pend_sym;
          push.last       = 1'b1;
          push.status     = pend_status;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rem        <= '0;
      cur_idx    <= '0;
      active     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      rem        <= rem_next;
      cur_idx    <= cur_idx_next;
      active     <= active_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fetch_idx   <= fetch_idx_next;
    fetch_ok    <= fetch_ok_next;
    check_leaf  <= check_leaf_next;
    bit_idx     <= bit_idx_next;
    data_reg    <= data_reg_next;
    root        <= root_next;
    pend_sym    <= pend_sym_next;
    pend_status <= pend_status_next;
  end

endmodule

/* rtl/prefix_code_tree_decoder_top.sv */
// prefix code tree decoder, top level
// depends on pctd_pkg, pctd_node_mem, pctd_walk_ctrl, pctd_result_reg
//
// input channel (in_valid/in_ready) carries ops: load writes one tree node,
// start sets the coded bit count and returns the walk to the root, data
// hands over eight coded bits taken lsb first (1 = right child, 0 = left).
// output channel (out_valid/out_ready) carries one transfer per decoded
// symbol, last set on the final one of a byte; a data byte before any start
// gives one transfer with status set and symbol 0.
// a data byte consumes one coded bit per cycle unless the output stalls the
// walk; each bit is one dependent read of the node table, whose single read
// port sets that pace.
// in_ready is high only while the sequencer is idle; a finished result may
// still wait in the output register meanwhile.
// when the receiver stalls, the walk holds at the next leaf until the
// output register frees up; nothing is dropped.
// reset clears the stream state and returns the walk to the root; the node
// table is not cleared and must be loaded before use.
module prefix_code_tree_decoder_top
  import pctd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [IDX_W-1:0]    node_index,
  input  logic                node_is_leaf,
  input  logic [IDX_W-1:0]    node_left,
  input  logic [IDX_W-1:0]    node_right,
  input  logic [SYM_W-1:0]    node_symbol,
  input  logic [CNT_IN_W-1:0] bit_count,
  input  logic [BYTE_W-1:0]   data_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SYM_W-1:0]    symbol,
  output logic                last,
  output logic                status
);

  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  node_t   mem_rdata;
  push_t   push;
  logic    out_free;

  pctd_node_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  pctd_walk_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .node_index   (node_index),
    .node_is_leaf (node_is_leaf),
    .node_left    (node_left),
    .node_right   (node_right),
    .node_symbol  (node_symbol),
    .bit_count    (bit_count),
    .data_byte    (data_byte),
    .mem_wr       (mem_wr),
    .mem_rd       (mem_rd),
    .mem_rdata    (mem_rdata),
    .push         (push),
    .out_free     (out_free)
  );

  pctd_result_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last),
    .status    (status)
  );

endmodule

/* tb/sv/pctd_decode_checker.sv */
`timescale 1ns / 1ps
// symbol stream checker for the prefix code tree decoder: follows both channels,
// keeps its own node table and walk state, compares every output transfer
// depends on pctd_pkg
module pctd_decode_checker
  import pctd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [IDX_W-1:0]    node_index,
  input  logic                node_is_leaf,
  input  logic [IDX_W-1:0]    node_left,
  input  logic [IDX_W-1:0]    node_right,
  input  logic [SYM_W-1:0]    node_symbol,
  input  logic [CNT_IN_W-1:0] bit_count,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [SYM_W-1:0]    symbol,
  input  logic                last,
  input  logic                status,
  output int                  mismatches,
  output int                  pending,
  output int                  results_checked
);

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             stat;
  } symbol_result_t;

  node_t                      code_tree [NODE_COUNT];
  logic [IDX_W-1:0]           walk_at;
  logic [BIT_COUNT_WIDTH-1:0] bits_left;
  logic                       stream_on;
  symbol_result_t             expected_symbols [$];

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
  end

  function automatic node_t fetch_node(input logic [IDX_W-1:0] idx);
    if (32'(idx) < NODE_COUNT) return code_tree[idx];
    return '0;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    node_t            cur;
    node_t            nxt;
    symbol_result_t   want;
    logic [SYM_W-1:0] found [BYTE_W];
    int               n;
    if (rst) begin
      walk_at   = '0;
      bits_left = '0;
      stream_on = 1'b0;
      expected_symbols.delete();
    end else begin
      // output side first so a transfer is never matched against the
      // item accepted at the same edge
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_symbols.size() == 0) begin
          flag_mismatch($sformatf("symbol %0h arrived with nothing pending", symbol));
        end else begin
          want = expected_symbols.pop_front();
          if (symbol !== want.sym)
            flag_mismatch($sformatf("symbol %0h, expected %0h", symbol, want.sym));
          if (last !== want.last)
            flag_mismatch($sformatf("last %0b, expected %0b", last, want.last));
          if (status !== want.stat)
            flag_mismatch($sformatf("status bit %0b, expected %0b", status, want.stat));
        end
      end
      if (in_valid && in_ready) begin
        case (op)
          OP_LOAD: begin
            if (32'(node_index) < NODE_COUNT)
              code_tree[node_index] = {node_is_leaf, node_left, node_right, node_symbol};
          end
          OP_START: begin
            bits_left = BIT_COUNT_WIDTH'(bit_count);
            walk_at   = '0;
            stream_on = 1'b1;
          end
          OP_DATA: begin
            if (!stream_on) begin
              expected_symbols.push_back({{SYM_W{1'b0}}, 1'b1, STAT_NO_STREAM});
            end else begin
              n = 0;
              for (int j = 0; j < BYTE_W && bits_left != 0; j++) begin
                cur       = fetch_node(walk_at);
                walk_at   = data_byte[j] ? cur.right : cur.left;
                bits_left = bits_left - BIT_COUNT_WIDTH'(1);
                nxt       = fetch_node(walk_at);
                if (nxt.leaf) begin
                  found[n] = nxt.sym;
                  n++;
                  walk_at = '0;
                end
              end
              for (int k = 0; k < n; k++)
                expected_symbols.push_back({found[k], k == n - 1, STAT_OK});
            end
          end
          default: begin
          end
        endcase
      end
    end
    pending <= expected_symbols.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// testbench top for the prefix code tree decoder: clock, reset, op stimulus,
// random output back-pressure and the final verdict
// depends on pctd_pkg, prefix_code_tree_decoder_top and pctd_decode_checker
module tb;
  import pctd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 200;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op           = '0;
  logic [IDX_W-1:0]    node_index   = '0;
  logic                node_is_leaf = 1'b0;
  logic [IDX_W-1:0]    node_left    = '0;
  logic [IDX_W-1:0]    node_right   = '0;
  logic [SYM_W-1:0]    node_symbol  = '0;
  logic [CNT_IN_W-1:0] bit_count    = '0;
  logic [BYTE_W-1:0]   data_byte    = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [SYM_W-1:0]    symbol;
  logic                last;
  logic                status;

  int mismatches;
  int pending;
  int results_checked;

  int cycle_count   = 0;
  int items_sent    = 0;
  bit no_idle       = 1'b0;
  bit stall_request = 1'b0;

  bit node_loaded [NODE_COUNT];
  int loaded_list [$];

  prefix_code_tree_decoder_top dut (.*);

  pctd_decode_checker checker_i (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d symbols still pending", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // output side: random wait per transfer, plus one long hold on request
  initial begin
    int pause;
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        pause = no_idle ? 0 : $urandom_range(0, 6);
        if (pause > 0) begin
          out_ready <= 1'b0;
          repeat (pause) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_op(input logic [OP_W-1:0] o, input logic [IDX_W-1:0] idx,
                         input logic lf, input logic [IDX_W-1:0] l,
                         input logic [IDX_W-1:0] r, input logic [SYM_W-1:0] sym,
                         input logic [CNT_IN_W-1:0] cnt, input logic [BYTE_W-1:0] d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    node_index   <= idx;
    node_is_leaf <= lf;
    node_left    <= l;
    node_right   <= r;
    node_symbol  <= sym;
    bit_count    <= cnt;
    data_byte    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (o != OP_UNUSED) items_sent++;
  endtask

  task automatic load_node(input int idx, input logic lf, input int l, input int r,
                           input logic [SYM_W-1:0] sym);
    if (!node_loaded[idx]) begin
      node_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    send_op(OP_LOAD, IDX_W'(idx), lf, IDX_W'(l), IDX_W'(r), sym,
            CNT_IN_W'({$urandom(), $urandom()}), BYTE_W'($urandom()));
  endtask

  task automatic send_start(input logic [CNT_IN_W-1:0] cnt);
    send_op(OP_START, IDX_W'($urandom()), 1'($urandom()), IDX_W'($urandom()),
            IDX_W'($urandom()), SYM_W'($urandom()), cnt, BYTE_W'($urandom()));
  endtask

  task automatic send_data(input logic [BYTE_W-1:0] d);
    send_op(OP_DATA, IDX_W'($urandom()), 1'($urandom()), IDX_W'($urandom()),
            IDX_W'($urandom()), SYM_W'($urandom()), CNT_IN_W'({$urandom(), $urandom()}), d);
  endtask

  task automatic send_noise();
    send_op(OP_UNUSED, IDX_W'($urandom()), 1'($urandom()), IDX_W'($urandom()),
            IDX_W'($urandom()), SYM_W'($urandom()), CNT_IN_W'({$urandom(), $urandom()}),
            BYTE_W'($urandom()));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [CNT_IN_W-1:0] pick_count();
    case ($urandom_range(0, 4))
      0, 1: return CNT_IN_W'($urandom_range(0, 40));
      2: return {CNT_IN_W{1'b1}};
      default: return CNT_IN_W'({$urandom(), $urandom()});
    endcase
  endfunction

  // random full binary tree rooted at node 0; every child index, leaves
  // included, points at a node of the same tree so no walk leaves the table
  task automatic plant_tree(input int leaves);
    bit               used    [NODE_COUNT];
    bit               is_tip  [NODE_COUNT];
    int               lchild  [NODE_COUNT];
    int               rchild  [NODE_COUNT];
    int               members [$];
    int               tips    [$];
    int               pick;
    int               parent;
    int               fresh;
    members.push_back(0);
    tips.push_back(0);
    used[0]   = 1'b1;
    is_tip[0] = 1'b1;
    repeat (leaves - 1) begin
      pick   = $urandom_range(0, tips.size() - 1);
      parent = tips[pick];
      tips.delete(pick);
      is_tip[parent] = 1'b0;
      for (int k = 0; k < 2; k++) begin
        do fresh = $urandom_range(1, NODE_COUNT - 1); while (used[fresh]);
        used[fresh]   = 1'b1;
        is_tip[fresh] = 1'b1;
        members.push_back(fresh);
        tips.push_back(fresh);
        if (k == 0) lchild[parent] = fresh;
        else rchild[parent] = fresh;
      end
    end
    foreach (tips[t]) begin
      lchild[tips[t]] = members[$urandom_range(0, members.size() - 1)];
      rchild[tips[t]] = members[$urandom_range(0, members.size() - 1)];
    end
    for (int k = members.size() - 1; k >= 0; k--)
      load_node(members[k], is_tip[members[k]], lchild[members[k]], rchild[members[k]],
                SYM_W'($urandom()));
  endtask

  // rewrite one node already in use; children stay within loaded nodes
  task automatic tweak_node();
    int sz;
    sz = loaded_list.size();
    load_node(loaded_list[$urandom_range(0, sz - 1)], 1'($urandom()),
              loaded_list[$urandom_range(0, sz - 1)], loaded_list[$urandom_range(0, sz - 1)],
              SYM_W'($urandom()));
  endtask

  initial begin
    int goal;
    int round;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // byte before any start, ignored op
    send_data(8'hA5);
    send_noise();
    // 0 -> 511, 10 -> 3, 11 0..0 1 -> 256; node 4 loops on a 0 bit
    load_node(511, 1'b1, 0, 0, 8'hFF);
    load_node(3, 1'b1, 0, 511, 8'h00);
    load_node(256, 1'b1, 0, 0, 8'h5A);
    load_node(4, 1'b0, 4, 256, 8'h00);
    load_node(2, 1'b0, 3, 4, 8'h33);
    load_node(0, 1'b0, 511, 2, 8'h00);
    send_start({CNT_IN_W{1'b1}});
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h03);
    send_data(8'h01);
    // count runs out mid byte, then zero count
    send_start(CNT_IN_W'(5));
    send_data(8'h00);
    send_data(8'hFF);
    send_start('0);
    send_data(8'h3C);
    // root as a leaf: every bit gives a symbol
    load_node(0, 1'b1, 0, 0, 8'h81);
    send_start(CNT_IN_W'(16));
    send_data(8'hC3);
    send_data(8'h5A);
    load_node(0, 1'b0, 511, 2, 8'h00);
    wait_drained();

    goal  = items_sent + RANDOM_ITEMS;
    round = 0;
    while (items_sent < goal) begin
      no_idle = (round % 5 == 3);
      if (round == 2)
        plant_tree($urandom_range(2, 4));
      else if (round == 0 || $urandom_range(0, 2) == 0)
        plant_tree(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12));
      send_start(pick_count());
      if (round == 2) begin
        send_start({CNT_IN_W{1'b1}});
        stall_request = 1'b1;
        repeat (12) send_data(BYTE_W'($urandom()));
      end
      repeat ($urandom_range(4, 12)) begin
        case ($urandom_range(0, 19))
          0: tweak_node();
          1: send_noise();
          2: send_start(pick_count());
          default: send_data(BYTE_W'($urandom()));
        endcase
      end
      if (round == 4 || $urandom_range(0, 5) == 0) wait_drained();
      round++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input transfers over %0d rounds, %0d tree nodes loaded",
             items_sent, round, loaded_list.size());
    $display("checked %0d symbol transfers, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
